[rtl/core/catb_pkg.sv]
// Package for the alignment-to-blocks parser: transaction payload types,
// parse modes, alignment character codes and output queue sizing.
// No dependencies; every other file imports it.
`default_nettype none

package catb_pkg;

    // Alignment string characters with a meaning of their own
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_CHAR  = 1'b1;

    // Output queue: a power of two, at least two entries
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_ALIGN = 2'd0,
        MODE_QINS  = 2'd1,
        MODE_TINS  = 2'd2
    } parse_mode_t;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  char_code;
        logic        last_char;
        logic [30:0] geno_start;
        logic [30:0] geno_end;
        logic [30:0] rep_start;
        logic [30:0] rep_end;
        logic        minus_strand;
        logic [30:0] repeat_size;
    } catb_in_t;

    typedef struct packed {
        logic               block_valid;
        logic signed [31:0] block_q_start;
        logic [30:0]        block_t_start;
        logic [30:0]        block_q_size;
        logic [30:0]        block_t_size;
        logic [30:0]        match_count;
        logic [30:0]        mismatch_count;
        logic               end_of_record;
        logic               bounds_error;
    } catb_out_t;

    // Results of one parse step, handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        catb_out_t  item0;
        catb_out_t  item1;
    } catb_push_t;

endpackage

`default_nettype wire

[rtl/core/catb_in_if.sv]
// Input channel: valid/ready handshake carrying one request transaction.
// Depends on catb_pkg for the payload type.
`default_nettype none

interface catb_in_if import catb_pkg::*; ();
    logic     valid;
    logic     ready;
    catb_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/catb_out_if.sv]
// Output channel: valid/ready handshake carrying one block transaction.
// Depends on catb_pkg for the payload type.
`default_nettype none

interface catb_out_if import catb_pkg::*; ();
    logic      valid;
    logic      ready;
    catb_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/catb_parse.sv]
// Parse state registers and the single-step next-state logic that turns one
// request transaction into up to two block results. Depends on catb_pkg.
`default_nettype none

module catb_parse import catb_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire catb_in_t   item,
    output catb_push_t      push
);

    localparam int C = COORD_BITS;

    parse_mode_t  mode_reg, mode_next;
    logic         open_reg, open_next;
    logic         pend_reg, pend_next;
    logic         skip_reg, skip_next;
    logic [C-1:0] tn_reg, tn_next;      // next target position
    logic [C-1:0] qn_reg, qn_next;      // next query position
    logic [C-1:0] te_reg, te_next;      // target end
    logic [C-1:0] qe_reg, qe_next;      // query end
    logic [C-1:0] cqs_reg, cqs_next;
    logic [C-1:0] cts_reg, cts_next;
    logic [C-1:0] cqz_reg, cqz_next;
    logic [C-1:0] ctz_reg, ctz_next;
    logic [C-1:0] cm_reg, cm_next;
    logic [C-1:0] cmm_reg, cmm_next;

    function automatic catb_out_t mk_block(
        input logic [C-1:0] qs, input logic [C-1:0] ts,
        input logic [C-1:0] qz, input logic [C-1:0] tz,
        input logic [C-1:0] m,  input logic [C-1:0] mm
    );
        catb_out_t r;
        r                = '0;
        r.block_valid    = 1'b1;
        r.block_q_start  = 32'(qs);
        r.block_t_start  = 31'(ts);
        r.block_q_size   = 31'(qz);
        r.block_t_size   = 31'(tz);
        r.match_count    = 31'(m);
        r.mismatch_count = 31'(mm);
        return r;
    endfunction

    always_comb
    begin
        logic       done;
        logic       err;
        logic [1:0] cnt;
        catb_out_t  r0;
        catb_out_t  r1;

        mode_next = mode_reg;
        open_next = open_reg;
        pend_next = pend_reg;
        skip_next = skip_reg;
        tn_next   = tn_reg;
        qn_next   = qn_reg;
        te_next   = te_reg;
        qe_next   = qe_reg;
        cqs_next  = cqs_reg;
        cts_next  = cts_reg;
        cqz_next  = cqz_reg;
        ctz_next  = ctz_reg;
        cm_next   = cm_reg;
        cmm_next  = cmm_reg;
        done      = 1'b0;
        err       = 1'b0;
        cnt       = 2'd0;
        r0        = '0;
        r1        = '0;

        if (fire)
        begin
            if (item.req_type == REQ_START)
            begin
                // drop any open parse and load the record coordinates
                mode_next = MODE_ALIGN;
                open_next = 1'b0;
                pend_next = 1'b0;
                skip_next = 1'b0;
                tn_next   = C'(item.geno_start);
                te_next   = C'(item.geno_end);
                if (item.minus_strand)
                begin
                    qn_next = C'(item.repeat_size) - C'(item.rep_end);
                    qe_next = C'(item.repeat_size) - (C'(item.rep_start) - C'(1));
                end
                else
                begin
                    qn_next = C'(item.rep_start) - C'(1);
                    qe_next = C'(item.rep_end);
                end
            end
            else if (skip_reg)
            begin
                // second base of a mismatch pair
                skip_next = 1'b0;
            end
            else
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    cqz_next  = cqz_next + C'(1);
                    ctz_next  = ctz_next + C'(1);
                    qn_next   = qn_next + C'(1);
                    tn_next   = tn_next + C'(1);
                    if (item.char_code == CH_SLASH)
                    begin
                        cmm_next  = cmm_next + C'(1);
                        skip_next = 1'b1;
                        done      = 1'b1;
                    end
                    else
                    begin
                        cm_next = cm_next + C'(1);
                    end
                end
                if (!done)
                begin
                    case (mode_next)
                        MODE_QINS:
                        begin
                            if (item.char_code == CH_PLUS)
                            begin
                                if (open_next)
                                begin
                                    r0  = mk_block(cqs_next, cts_next, cqz_next,
                                                   ctz_next, cm_next, cmm_next);
                                    cnt = 2'd1;
                                end
                                open_next = 1'b0;
                                mode_next = MODE_ALIGN;
                            end
                            else
                            begin
                                qn_next  = qn_next + C'(1);
                                cqz_next = cqz_next + C'(1);
                            end
                        end
                        MODE_TINS:
                        begin
                            if (item.char_code == CH_MINUS)
                            begin
                                if (open_next)
                                begin
                                    r0  = mk_block(cqs_next, cts_next, cqz_next,
                                                   ctz_next, cm_next, cmm_next);
                                    cnt = 2'd1;
                                end
                                open_next = 1'b0;
                                mode_next = MODE_ALIGN;
                            end
                            else
                            begin
                                tn_next  = tn_next + C'(1);
                                ctz_next = ctz_next + C'(1);
                            end
                        end
                        default:
                        begin
                            if (item.char_code == CH_PLUS || item.char_code == CH_MINUS)
                            begin
                                // close the aligned run, open the insert
                                if (open_next)
                                begin
                                    r0  = mk_block(cqs_next, cts_next, cqz_next,
                                                   ctz_next, cm_next, cmm_next);
                                    cnt = 2'd1;
                                end
                                cqs_next  = qn_next;
                                cts_next  = tn_next;
                                cqz_next  = '0;
                                ctz_next  = '0;
                                cm_next   = '0;
                                cmm_next  = '0;
                                open_next = 1'b1;
                                mode_next = (item.char_code == CH_PLUS) ? MODE_QINS
                                                                         : MODE_TINS;
                            end
                            else
                            begin
                                mode_next = MODE_ALIGN;
                                if (!open_next)
                                begin
                                    cqs_next  = qn_next;
                                    cts_next  = tn_next;
                                    cqz_next  = '0;
                                    ctz_next  = '0;
                                    cm_next   = '0;
                                    cmm_next  = '0;
                                    open_next = 1'b1;
                                end
                                pend_next = 1'b1;
                            end
                        end
                    endcase
                end
            end

            if (item.last_char)
            begin
                // settle a held base, close the block, flag the record end
                if (pend_next)
                begin
                    pend_next = 1'b0;
                    cm_next   = cm_next + C'(1);
                    cqz_next  = cqz_next + C'(1);
                    ctz_next  = ctz_next + C'(1);
                    qn_next   = qn_next + C'(1);
                    tn_next   = tn_next + C'(1);
                end
                if (open_next)
                begin
                    if (cnt == 2'd0)
                    begin
                        r0 = mk_block(cqs_next, cts_next, cqz_next,
                                      ctz_next, cm_next, cmm_next);
                    end
                    else
                    begin
                        r1 = mk_block(cqs_next, cts_next, cqz_next,
                                      ctz_next, cm_next, cmm_next);
                    end
                    cnt = cnt + 2'd1;
                end
                if (cnt == 2'd0)
                begin
                    cnt = 2'd1;
                end
                err = ($signed(tn_next) > $signed(te_next))
                   || ($signed(qn_next) > $signed(qe_next));
                if (cnt == 2'd1)
                begin
                    r0.end_of_record = 1'b1;
                    r0.bounds_error  = err;
                end
                else
                begin
                    r1.end_of_record = 1'b1;
                    r1.bounds_error  = err;
                end
                mode_next = MODE_ALIGN;
                open_next = 1'b0;
                pend_next = 1'b0;
                skip_next = 1'b0;
            end
        end

        push.count = cnt;
        push.item0 = r0;
        push.item1 = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ALIGN;
            open_reg <= 1'b0;
            pend_reg <= 1'b0;
            skip_reg <= 1'b0;
            tn_reg   <= '0;
            qn_reg   <= '0;
            te_reg   <= '0;
            qe_reg   <= '0;
            cqs_reg  <= '0;
            cts_reg  <= '0;
            cqz_reg  <= '0;
            ctz_reg  <= '0;
            cm_reg   <= '0;
            cmm_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            open_reg <= open_next;
            pend_reg <= pend_next;
            skip_reg <= skip_next;
            tn_reg   <= tn_next;
            qn_reg   <= qn_next;
            te_reg   <= te_next;
            qe_reg   <= qe_next;
            cqs_reg  <= cqs_next;
            cts_reg  <= cts_next;
            cqz_reg  <= cqz_next;
            ctz_reg  <= ctz_next;
            cm_reg   <= cm_next;
            cmm_reg  <= cmm_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/catb_outq.sv]
// Output queue: takes up to two block results per cycle and presents them
// one transaction at a time. Depends on catb_pkg and catb_out_if.
`default_nettype none

module catb_outq import catb_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire catb_push_t push,
    output logic            room,
    catb_out_if.source      blocks
);

    catb_out_t                  entry_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_BITS-1:0]   count_reg, count_next;
    logic                       pop;
    logic [OUTQ_PTR_BITS-1:0]   wr_ptr_second;

    // room for a worst-case step of two results
    assign room          = count_reg <= OUTQ_CNT_BITS'(OUTQ_DEPTH - 2);
    assign blocks.valid  = count_reg != '0;
    assign blocks.data   = entry_reg[rd_ptr_reg];
    assign pop           = blocks.valid && blocks.ready;
    assign wr_ptr_second = wr_ptr_reg + OUTQ_PTR_BITS'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUTQ_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + OUTQ_PTR_BITS'(pop);
        count_next  = count_reg + OUTQ_CNT_BITS'(push.count) - OUTQ_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.item0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_second] <= push.item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/compressed_alignment_to_blocks.sv]
// Top level of the merged-diff alignment parser: parse step plus output queue.
// Depends on catb_pkg, catb_in_if, catb_out_if, catb_parse and catb_outq.
//
//   Channel   Role    Transaction payload
//   -------   -----   ------------------------------------------------------
//   chars     sink    record start (coordinates, strand) or one string char
//   blocks    source  one alignment block, or an end marker with flags
//
// Cycles: one request transaction per cycle while the queue has room; each is
// parsed in the cycle it is taken, and its zero, one or two results land in a
// four-entry output queue; they appear on blocks from the next cycle on, one
// per cycle while blocks is ready. The input is taken whenever the queue has
// two free entries, so a stalled blocks side stalls chars once three are held.
// Reset: rst_n clears the parse state, the coordinates and the queue at once.
`default_nettype none

module compressed_alignment_to_blocks import catb_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    catb_in_if.sink     chars,
    catb_out_if.source  blocks
);

    catb_push_t push;
    logic       room;
    logic       fire;

    // take a request only while the queue can hold its worst case
    assign chars.ready = room;
    assign fire        = chars.valid && chars.ready;

    catb_parse #(
        .COORD_BITS (COORD_BITS)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (chars.data),
        .push  (push)
    );

    catb_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .blocks (blocks)
    );

    // a request that produced results must show a block on the next cycle
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |=> blocks.valid)
        else $error("results produced but output not valid");

    // the end of a string always yields a result
    a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
        fire && chars.data.last_char |-> push.count != 2'd0)
        else $error("end of string produced no result");

    // a result with no block exists only to carry the record end
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        blocks.valid && !blocks.data.block_valid |-> blocks.data.end_of_record)
        else $error("empty result without end of record");

    // bounds error travels only with the record end
    a_err_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        blocks.valid && blocks.data.bounds_error |-> blocks.data.end_of_record)
        else $error("bounds error outside record end");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for compressed_alignment_to_blocks: drives record starts and
// alignment characters, predicts every block and end marker, and checks them in order.
// Depends on catb_pkg, catb_in_if, catb_out_if and the parser RTL.
`timescale 1ns / 1ps

module testbench;
    import catb_pkg::*;

    localparam int REQUEST_TARGET = 1300;
    localparam int CALM_TAIL      = 150;
    localparam int PRESSURE_AT    = 400;
    localparam int PRESSURE_LEN   = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 400000;

    // Block predictor plus the queue of blocks it still expects to see.
    class block_scoreboard;
        parse_mode_t mode;
        bit          blk_open;
        bit          base_held;
        bit          skip_char;
        logic [31:0] t_next, q_next, t_end, q_end;
        logic [31:0] b_q_start, b_t_start, b_q_size, b_t_size, b_match, b_mismatch;
        catb_out_t   step_out [2];
        int          step_n;
        catb_out_t   want_q [$];
        int          errors, requests, blocks_seen, markers_seen, bounds_seen;

        function new();
            clear_parse();
            t_next = '0;
            q_next = '0;
            t_end = '0;
            q_end = '0;
            b_q_start = '0;
            b_t_start = '0;
            b_q_size = '0;
            b_t_size = '0;
            b_match = '0;
            b_mismatch = '0;
        endfunction

        function void clear_parse();
            mode = MODE_ALIGN;
            blk_open = 1'b0;
            base_held = 1'b0;
            skip_char = 1'b0;
        endfunction

        function catb_out_t block_word(bit with_block);
            catb_out_t w;
            w = '0;
            if (with_block)
            begin
                w.block_valid    = 1'b1;
                w.block_q_start  = b_q_start;
                w.block_t_start  = b_t_start[30:0];
                w.block_q_size   = b_q_size[30:0];
                w.block_t_size   = b_t_size[30:0];
                w.match_count    = b_match[30:0];
                w.mismatch_count = b_mismatch[30:0];
            end
            return w;
        endfunction

        function void open_block();
            b_q_start = q_next;
            b_t_start = t_next;
            b_q_size = '0;
            b_t_size = '0;
            b_match = '0;
            b_mismatch = '0;
            blk_open = 1'b1;
        endfunction

        function void close_block();
            if (blk_open && step_n < 2)
            begin
                step_out[step_n] = block_word(1'b1);
                step_n++;
            end
            blk_open = 1'b0;
        endfunction

        function void resolve_base(bit mismatch);
            base_held = 1'b0;
            if (mismatch)
                b_mismatch = b_mismatch + 32'd1;
            else
                b_match = b_match + 32'd1;
            b_q_size = b_q_size + 32'd1;
            b_t_size = b_t_size + 32'd1;
            q_next = q_next + 32'd1;
            t_next = t_next + 32'd1;
        endfunction

        // Advance the model by one accepted request and queue what it produces.
        function void note_request(catb_in_t r);
            bit         consumed;
            logic [7:0] c;
            c = r.char_code;
            step_n = 0;
            requests++;
            if (r.req_type == REQ_START)
            begin
                clear_parse();
                t_next = {1'b0, r.geno_start};
                t_end = {1'b0, r.geno_end};
                if (r.minus_strand)
                begin
                    q_next = {1'b0, r.repeat_size} - {1'b0, r.rep_end};
                    q_end = {1'b0, r.repeat_size} - ({1'b0, r.rep_start} - 32'd1);
                end
                else
                begin
                    q_next = {1'b0, r.rep_start} - 32'd1;
                    q_end = {1'b0, r.rep_end};
                end
            end
            else if (skip_char)
                skip_char = 1'b0;
            else
            begin
                consumed = 1'b0;
                if (base_held)
                begin
                    if (c == CH_SLASH)
                    begin
                        resolve_base(1'b1);
                        skip_char = 1'b1;
                        consumed = 1'b1;
                    end
                    else
                        resolve_base(1'b0);
                end
                if (!consumed)
                begin
                    case (mode)
                        MODE_QINS:
                            if (c == CH_PLUS)
                            begin
                                close_block();
                                mode = MODE_ALIGN;
                            end
                            else
                            begin
                                q_next = q_next + 32'd1;
                                b_q_size = b_q_size + 32'd1;
                            end
                        MODE_TINS:
                            if (c == CH_MINUS)
                            begin
                                close_block();
                                mode = MODE_ALIGN;
                            end
                            else
                            begin
                                t_next = t_next + 32'd1;
                                b_t_size = b_t_size + 32'd1;
                            end
                        default:
                            if (c == CH_PLUS || c == CH_MINUS)
                            begin
                                close_block();
                                open_block();
                                mode = (c == CH_PLUS) ? MODE_QINS : MODE_TINS;
                            end
                            else
                            begin
                                mode = MODE_ALIGN;
                                if (!blk_open)
                                    open_block();
                                base_held = 1'b1;
                            end
                    endcase
                end
            end
            if (r.last_char)
            begin
                if (base_held)
                    resolve_base(1'b0);
                close_block();
                if (step_n == 0)
                begin
                    step_out[0] = block_word(1'b0);
                    step_n = 1;
                end
                step_out[step_n - 1].end_of_record = 1'b1;
                step_out[step_n - 1].bounds_error =
                    ($signed(t_next) > $signed(t_end)) || ($signed(q_next) > $signed(q_end));
                clear_parse();
            end
            for (int i = 0; i < step_n; i++)
                want_q.push_back(step_out[i]);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_block(catb_out_t got);
            catb_out_t want;
            if (want_q.size() == 0)
            begin
                $error("block transaction with nothing expected: %p", got);
                errors++;
                return;
            end
            want = want_q.pop_front();
            compare("block_valid", 32'(want.block_valid), 32'(got.block_valid));
            compare("block_q_start", want.block_q_start, got.block_q_start);
            compare("block_t_start", 32'(want.block_t_start), 32'(got.block_t_start));
            compare("block_q_size", 32'(want.block_q_size), 32'(got.block_q_size));
            compare("block_t_size", 32'(want.block_t_size), 32'(got.block_t_size));
            compare("match_count", 32'(want.match_count), 32'(got.match_count));
            compare("mismatch_count", 32'(want.mismatch_count), 32'(got.mismatch_count));
            compare("end_of_record", 32'(want.end_of_record), 32'(got.end_of_record));
            compare("bounds_error", 32'(want.bounds_error), 32'(got.bounds_error));
            if (want.block_valid)
                blocks_seen++;
            if (want.end_of_record)
                markers_seen++;
            if (want.bounds_error)
                bounds_seen++;
        endfunction

        function int outstanding();
            return want_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    catb_in_if  chars_if ();
    catb_out_if blocks_if ();

    compressed_alignment_to_blocks u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .blocks (blocks_if)
    );

    block_scoreboard board = new();

    // Shared control between the request driver and the block receiver
    int  sent;          // request transactions accepted so far
    int  cycle_count;
    bit  calm;          // tail of the run: no idling on either side
    bit  busy;          // current record is sent back to back
    bit  hold_req;      // ask the receiver for one long hold-off
    byte unsigned text [$];
    string bases = "ACGTNacgt";

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: end the run if the handshakes never drain.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Present one request and hold it until the parser takes it. Valid stays high
    // into the next request unless a gap is inserted, so it is never dropped and
    // raised in the same step.
    task automatic send_item(input catb_in_t item);
        int gap;
        if (!calm && !busy && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.data <= item;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        board.note_request(item);
        sent++;
        if (sent == PRESSURE_AT)
            hold_req = 1'b1;
        if (sent == REQUEST_TARGET - CALM_TAIL)
            calm = 1'b1;
    endtask

    // Coordinate fields ride along with junk on character requests; the parser
    // must ignore them.
    task automatic send_char(input logic [7:0] code, input bit last);
        catb_in_t     item;
        logic [191:0] junk;
        junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        item = junk[$bits(catb_in_t)-1:0];
        item.req_type = REQ_CHAR;
        item.char_code = code;
        item.last_char = last;
        send_item(item);
    endtask

    task automatic send_start(input logic [30:0] gs, input logic [30:0] ge,
                              input logic [30:0] rs, input logic [30:0] re,
                              input bit minus, input logic [30:0] sz, input bit last);
        catb_in_t item;
        item.req_type = REQ_START;
        item.char_code = 8'($urandom_range(0, 255));
        item.last_char = last;
        item.geno_start = gs;
        item.geno_end = ge;
        item.rep_start = rs;
        item.rep_end = re;
        item.minus_strand = minus;
        item.repeat_size = sz;
        send_item(item);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // Send the built text; leave the record open when close is clear.
    task automatic send_text(input bit close);
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], close && i == text.size() - 1);
    endtask

    // Record start with coordinates near the text length, so bounds errors come
    // and go; now and then every field is fully random.
    task automatic send_random_start(input bit empty);
        logic [30:0] gs, rs, re;
        gs = 31'($urandom);
        rs = 31'($urandom);
        re = rs - 31'd1 + 31'($urandom_range(0, 30));
        if ($urandom_range(0, 3) == 0)
            send_start(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
                       1'($urandom_range(0, 1)), 31'($urandom), empty);
        else
            send_start(gs, gs + 31'($urandom_range(0, 30)), rs, re,
                       1'($urandom_range(0, 1)), re + 31'($urandom_range(0, 40)), empty);
    endtask

    function automatic byte unsigned pick_base();
        return bases[$urandom_range(0, bases.len() - 1)];
    endfunction

    // Build a well-formed alignment text: base runs, x/y mismatches and
    // +...+ / -...- inserts, with an occasional open tail.
    function automatic void build_text();
        text.delete();
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 4))
                0, 1: repeat ($urandom_range(1, 8)) text.push_back(pick_base());
                2:
                begin
                    text.push_back(pick_base());
                    text.push_back(CH_SLASH);
                    text.push_back(pick_base());
                end
                3:
                begin
                    text.push_back(CH_PLUS);
                    repeat ($urandom_range(0, 5)) text.push_back(pick_base());
                    text.push_back(CH_PLUS);
                end
                default:
                begin
                    text.push_back(CH_MINUS);
                    repeat ($urandom_range(0, 5)) text.push_back(pick_base());
                    text.push_back(CH_MINUS);
                end
            endcase
        end
        case ($urandom_range(0, 9))
            0:
            begin
                text.push_back(pick_base());
                text.push_back(CH_SLASH);
            end
            1:
            begin
                text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                repeat ($urandom_range(0, 3)) text.push_back(pick_base());
            end
            default: ;
        endcase
    endfunction

    // Noise: marks are heavily favored so stray slashes and nested marks show up.
    function automatic void build_noise();
        text.delete();
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 5))
                0: text.push_back(CH_PLUS);
                1: text.push_back(CH_MINUS);
                2: text.push_back(CH_SLASH);
                default: text.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // Receiver: random ready bursts, one long hold-off on request, then always ready.
    initial
    begin
        int  run_left;
        bit  rdy;
        bit  hold_done;
        run_left = 0;
        rdy = 1'b0;
        hold_done = 1'b0;
        blocks_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (blocks_if.valid && blocks_if.ready)
                board.check_block(blocks_if.data);
            if (run_left > 0)
                run_left--;
            else if (hold_req && !hold_done)
            begin
                // Long stall: the output queue fills and chars must back up
                hold_done = 1'b1;
                rdy = 1'b0;
                run_left = PRESSURE_LEN;
            end
            else if (calm)
                rdy = 1'b1;
            else if ($urandom_range(0, 2) == 0)
            begin
                rdy = 1'b0;
                run_left = $urandom_range(1, 19);
            end
            else
            begin
                rdy = 1'b1;
                run_left = $urandom_range(0, 40);
            end
            blocks_if.ready <= rdy;
        end
    end

    // Main sequence: reset, directed cases, random records, drain, verdict.
    initial
    begin
        int kind;
        sent = 0;
        calm = 1'b0;
        busy = 1'b0;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        chars_if.valid <= 1'b0;
        chars_if.data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Characters before any record start parse against zero coordinates;
        // the byte after the slash is swallowed even when it ends the string.
        send_char(8'h00, 1'b0);
        send_char(CH_SLASH, 1'b0);
        send_char(8'hFF, 1'b1);
        // Empty string with every coordinate at its maximum, minus strand
        send_start(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1,
                   31'h7FFFFFFF, 1'b1);
        // Zero repeat start wraps the query start to -1; the text covers a
        // mismatch, an insert holding the other mark, empty inserts, and an
        // insert left open by the end of the string.
        send_start(31'd100, 31'd112, 31'd0, 31'd20, 1'b0, 31'd0, 1'b0);
        send_string("AC/T+-g+++-+--");
        // Minus strand record dropped mid-string by a fresh record start
        send_start(31'd50, 31'd60, 31'd1, 31'd10, 1'b1, 31'd30, 1'b0);
        send_char("A", 1'b0);
        send_char("C", 1'b0);
        // Zero-size target range; string ends right after the slash
        send_start(31'd0, 31'd0, 31'd1, 31'd0, 1'b0, 31'd0, 1'b0);
        send_string("G/");

        while (sent < REQUEST_TARGET)
        begin
            kind = $urandom_range(0, 9);
            busy = ($urandom_range(0, 3) == 0);
            if (kind < 7)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_random_start(1'b1);
                else
                begin
                    build_text();
                    send_random_start(1'b0);
                    send_text(1'b1);
                end
            end
            else if (kind == 7)
            begin
                build_noise();
                send_random_start(1'b0);
                send_text(1'b1);
            end
            else if (kind == 8)
            begin
                // Broken record: the next record start drops it
                build_text();
                send_random_start(1'b0);
                send_text(1'b0);
            end
            else
            begin
                // No record start: parse against whatever coordinates are held
                build_text();
                send_text(1'b1);
            end
        end

        chars_if.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests in %0d cycles: %0d blocks and %0d record ends",
                 board.requests, cycle_count, board.blocks_seen, board.markers_seen);
        $display("%0d record ends flagged a bounds overrun; %0d mismatching fields",
                 board.bounds_seen, board.errors);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
